/* hdl/modbus_write_frame_builder_macros.svh */
// assertion macros shared by the frame builder modules
`ifndef MODBUS_WRITE_FRAME_BUILDER_MACROS_SVH
`define MODBUS_WRITE_FRAME_BUILDER_MACROS_SVH

// condition implies consequence on the same edge, checked outside reset
`define MWFB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition must never hold, checked outside reset
`define MWFB_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

/* hdl/mwfb_pkg.sv */
// types, constants and the crc step shared by the frame builder
`timescale 1ns / 1ps

package mwfb_pkg;

	// drive command codes
	typedef enum logic [2:0] {
		OP_LEFT_SPEED  = 3'd0,
		OP_VEL_MODE    = 3'd1,
		OP_STOP        = 3'd2,
		OP_ENABLE      = 3'd3,
		OP_CLEAR_ALARM = 3'd4
	} opcode_t;

	// frame byte positions in transmission order
	typedef enum logic [2:0] {
		BYTE_DEV     = 3'd0,
		BYTE_FUNC    = 3'd1,
		BYTE_ADDR_HI = 3'd2,
		BYTE_ADDR_LO = 3'd3,
		BYTE_VAL_HI  = 3'd4,
		BYTE_VAL_LO  = 3'd5,
		BYTE_CRC_LO  = 3'd6,
		BYTE_CRC_HI  = 3'd7
	} byte_sel_t;

	// configuration register indexes
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 8;
	localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ID    = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_REVERSE = 1'b1;
	localparam logic [7:0] DEVICE_ID_RESET = 8'h01;

	// frame constants
	localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
	localparam logic [7:0]  REG_PAGE          = 8'h20;
	localparam logic [7:0]  ADDR_LO_SPEED     = 8'h88;
	localparam logic [7:0]  ADDR_LO_MODE      = 8'h0D;
	localparam logic [7:0]  ADDR_LO_CTRL      = 8'h0E;
	localparam logic [15:0] VAL_VEL_MODE      = 16'h0003;
	localparam logic [15:0] VAL_STOP          = 16'h0007;
	localparam logic [15:0] VAL_ENABLE        = 16'h0008;
	localparam logic [15:0] VAL_CLEAR_ALARM   = 16'h0006;
	localparam logic signed [15:0] SPEED_LIMIT = 16'sd2999;
	localparam logic [15:0] CRC_INIT          = 16'hFFFF;
	localparam logic [15:0] CRC_POLY          = 16'hA001;

	typedef struct packed {
		logic [7:0]  device_id;
		logic        left_reverse;
	} cfg_t;

	// one classified command waiting for serialization
	typedef struct packed {
		logic [7:0]  dev_id;
		logic [7:0]  addr_lo;
		logic [15:0] value;
	} frame_desc_t;

	// reflected crc-16 update over one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

/* hdl/mwfb_cmd_if.sv */
// command channel: opcode and left speed with valid/ready
`timescale 1ns / 1ps

interface mwfb_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         opcode;
	logic signed [15:0] left_speed;

	modport source (output valid, output opcode, output left_speed, input ready);
	modport sink (input valid, input opcode, input left_speed, output ready);
endinterface

/* hdl/mwfb_byte_if.sv */
// byte channel: frame bytes with a last marker and valid/ready
`timescale 1ns / 1ps

interface mwfb_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last;

	modport source (output valid, output frame_byte, output last, input ready);
	modport sink (input valid, input frame_byte, input last, output ready);
endinterface

/* hdl/mwfb_front.sv */
// front end: takes commands, drops unused codes, builds the register address and value
`timescale 1ns / 1ps

module mwfb_front (
	input  logic                 clk,
	input  logic                 arst_n,
	mwfb_cmd_if.sink             cmd,
	input  mwfb_pkg::cfg_t       cfg,
	output logic                 desc_valid,
	input  logic                 desc_ready,
	output mwfb_pkg::frame_desc_t desc
);

	logic                  v_s1;
	mwfb_pkg::frame_desc_t desc_s1;
	mwfb_pkg::frame_desc_t desc_d;
	logic                  known;
	logic                  accept;
	logic signed [15:0]    spd_raw;
	logic signed [15:0]    spd_sat;

	assign cmd.ready  = !v_s1 || desc_ready;
	assign accept     = cmd.valid && cmd.ready;
	assign desc_valid = v_s1;
	assign desc       = desc_s1;

	// optional negation with 16-bit wrap, then clamp to the speed limit
	always_comb begin
		spd_raw = cfg.left_reverse ? 16'(16'sd0 - cmd.left_speed) : cmd.left_speed;
		if (spd_raw > mwfb_pkg::SPEED_LIMIT) begin
			spd_sat = mwfb_pkg::SPEED_LIMIT;
		end else if (spd_raw < -mwfb_pkg::SPEED_LIMIT) begin
			spd_sat = 16'(-mwfb_pkg::SPEED_LIMIT);
		end else begin
			spd_sat = spd_raw;
		end
	end

	// classify the command into address low byte and value
	always_comb begin
		known          = 1'b1;
		desc_d.dev_id  = cfg.device_id;
		desc_d.addr_lo = mwfb_pkg::ADDR_LO_CTRL;
		desc_d.value   = mwfb_pkg::VAL_STOP;
		unique case (mwfb_pkg::opcode_t'(cmd.opcode))
			mwfb_pkg::OP_LEFT_SPEED: begin
				desc_d.addr_lo = mwfb_pkg::ADDR_LO_SPEED;
				desc_d.value   = spd_sat;
			end
			mwfb_pkg::OP_VEL_MODE: begin
				desc_d.addr_lo = mwfb_pkg::ADDR_LO_MODE;
				desc_d.value   = mwfb_pkg::VAL_VEL_MODE;
			end
			mwfb_pkg::OP_STOP: begin
				desc_d.value = mwfb_pkg::VAL_STOP;
			end
			mwfb_pkg::OP_ENABLE: begin
				desc_d.value = mwfb_pkg::VAL_ENABLE;
			end
			mwfb_pkg::OP_CLEAR_ALARM: begin
				desc_d.value = mwfb_pkg::VAL_CLEAR_ALARM;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	// stage valid: unused codes leave no entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= known;
		end else if (desc_ready) begin
			v_s1 <= 1'b0;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= desc_d;
		end
	end

endmodule

/* hdl/mwfb_queue.sv */
// short first-in first-out queue of frame descriptors between front and back
`timescale 1ns / 1ps
`include "modbus_write_frame_builder_macros.svh"

module mwfb_queue #(
	parameter int DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  mwfb_pkg::frame_desc_t push_data,
	output logic                  pop_valid,
	input  logic                  pop,
	output mwfb_pkg::frame_desc_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mwfb_pkg::frame_desc_t mem_q [DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  push;

	assign push_ready = cnt_q != CNT_W'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= CNT_W'(cnt_q + 1'b1);
				2'b01:   cnt_q <= CNT_W'(cnt_q - 1'b1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`MWFB_ASSERT_NEVER(a_cnt_bound, cnt_q > CNT_W'(DEPTH), "queue count above depth")
	`MWFB_ASSERT_IMP(a_pop_nonempty, pop, cnt_q != '0, "pop from empty queue")

endmodule

/* hdl/mwfb_back.sv */
// back end: serializes one descriptor into eight frame bytes with a running crc
`timescale 1ns / 1ps
`include "modbus_write_frame_builder_macros.svh"

module mwfb_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  desc_valid,
	input  mwfb_pkg::frame_desc_t desc,
	output logic                  desc_pop,
	mwfb_byte_if.source           frame
);

	mwfb_pkg::byte_sel_t idx_q;
	logic [15:0]         crc_q;
	logic                out_v_q;
	logic [7:0]          byte_q;
	logic                last_q;
	logic                adv;
	logic [7:0]          byte_d;
	logic [15:0]         crc_base;
	logic [15:0]         crc_next;

	assign adv         = desc_valid && (!out_v_q || frame.ready);
	assign desc_pop    = adv && (idx_q == mwfb_pkg::BYTE_CRC_HI);
	assign frame.valid = out_v_q;
	assign frame.frame_byte = byte_q;
	assign frame.last  = last_q;

	// pick the byte for the current position
	always_comb begin
		unique case (idx_q)
			mwfb_pkg::BYTE_DEV:     byte_d = desc.dev_id;
			mwfb_pkg::BYTE_FUNC:    byte_d = mwfb_pkg::FUNC_WRITE_SINGLE;
			mwfb_pkg::BYTE_ADDR_HI: byte_d = mwfb_pkg::REG_PAGE;
			mwfb_pkg::BYTE_ADDR_LO: byte_d = desc.addr_lo;
			mwfb_pkg::BYTE_VAL_HI:  byte_d = desc.value[15:8];
			mwfb_pkg::BYTE_VAL_LO:  byte_d = desc.value[7:0];
			mwfb_pkg::BYTE_CRC_LO:  byte_d = crc_q[7:0];
			mwfb_pkg::BYTE_CRC_HI:  byte_d = crc_q[15:8];
		endcase
	end

	// running crc, seeded on the first byte
	assign crc_base = (idx_q == mwfb_pkg::BYTE_DEV) ? mwfb_pkg::CRC_INIT : crc_q;
	assign crc_next = mwfb_pkg::crc_byte(crc_base, byte_d);

	// position counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= mwfb_pkg::BYTE_DEV;
			out_v_q <= 1'b0;
		end else if (adv) begin
			idx_q   <= mwfb_pkg::byte_sel_t'(idx_q + 3'd1);
			out_v_q <= 1'b1;
		end else if (frame.ready) begin
			out_v_q <= 1'b0;
		end
	end

	// output byte and crc accumulator
	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q <= byte_d;
			last_q <= idx_q == mwfb_pkg::BYTE_CRC_HI;
			if (idx_q < mwfb_pkg::BYTE_CRC_LO) begin
				crc_q <= crc_next;
			end
		end
	end

	`MWFB_ASSERT_IMP(a_mid_frame_desc, idx_q != mwfb_pkg::BYTE_DEV, desc_valid,
		"descriptor lost in the middle of a frame")
	`MWFB_ASSERT_IMP(a_last_wraps, out_v_q && last_q, idx_q == mwfb_pkg::BYTE_DEV,
		"last byte shown while position not back at start")

endmodule

/* hdl/modbus_write_frame_builder.sv */
// top level: modbus rtu write-single-register frame builder
//
//  channel  dir  transfer          payload
//  cmd      in   valid && ready    opcode[2:0], left_speed[15:0] signed
//  frame    out  valid && ready    frame_byte[7:0], last
//  cfg      in   cfg_we            cfg_index[0:0], cfg_data[7:0]
//
// each valid command yields eight bytes, one per cycle while frame is ready, so the
// byte-serial back end sets the sustained command rate; unused codes produce no bytes
// a command passes the front stage register, then the queue write, then the output
// reg before its first byte is valid
// commands keep transferring each cycle while the descriptor queue has room
// reset sets device_id to 1 and left_reverse to 0; there is no clearing pass
// a stall on frame holds the output register and backs up into the queue and cmd
`timescale 1ns / 1ps

module modbus_write_frame_builder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mwfb_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [mwfb_pkg::CFG_DATA_W-1:0]    cfg_data,
	mwfb_cmd_if.sink                           cmd,
	mwfb_byte_if.source                        frame
);

	mwfb_pkg::cfg_t        cfg_q;
	logic                  f_valid;
	logic                  f_ready;
	mwfb_pkg::frame_desc_t f_desc;
	logic                  q_valid;
	logic                  q_pop;
	mwfb_pkg::frame_desc_t q_desc;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_id    <= mwfb_pkg::DEVICE_ID_RESET;
			cfg_q.left_reverse <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mwfb_pkg::CFG_DEVICE_ID:    cfg_q.device_id    <= cfg_data;
				mwfb_pkg::CFG_LEFT_REVERSE: cfg_q.left_reverse <= cfg_data[0];
			endcase
		end
	end

	// command classification
	mwfb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg_q),
		.desc_valid (f_valid),
		.desc_ready (f_ready),
		.desc       (f_desc)
	);

	// decoupling queue
	mwfb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_desc),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_data   (q_desc)
	);

	// byte serializer
	mwfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc_valid (q_valid),
		.desc       (q_desc),
		.desc_pop   (q_pop),
		.frame      (frame)
	);

endmodule

/* bench/mwfb_frame_checker.sv */
// scoreboard for the frame builder: predicts frame bytes per command and compares transfers
`timescale 1ns / 1ps

module mwfb_frame_checker
	import mwfb_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	mwfb_cmd_if                    cmd_mon,
	mwfb_byte_if                   frame_mon,
	output int                     mismatches,
	output int                     bytes_due,
	output int                     bytes_checked
);

	// eight frame bytes, index 0 goes out first
	typedef logic [7:0][7:0] wire_frame_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
		int         frame_no;
		int         pos;
	} due_byte_t;

	due_byte_t  bytes_expected[$];
	logic [7:0] dev_id_shadow;
	logic       reverse_shadow;
	int         fail_count;
	int         checked_count;
	int         frame_count;

	// optional negation with 16-bit wrap, then saturation to the speed limit
	function automatic logic [15:0] clamp_speed(input logic [15:0] raw, input logic rev);
		logic [15:0]        u;
		logic signed [15:0] s;
		u = raw;
		if (rev)
			u = 16'd0 - u;
		s = signed'(u);
		if (s > SPEED_LIMIT)
			s = SPEED_LIMIT;
		else if (s < -SPEED_LIMIT)
			s = -SPEED_LIMIT;
		return s;
	endfunction

	// modbus crc-16 over the six header and value bytes
	function automatic logic [15:0] modbus_crc(input wire_frame_t f);
		logic [15:0] c;
		int          i;
		int          b;
		c = CRC_INIT;
		for (i = 0; i < 6; i++) begin
			c = c ^ {8'h00, f[i]};
			for (b = 0; b < 8; b++)
				c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// whole frame for one command; returns 0 for codes that produce nothing
	function automatic logic build_frame(input logic [2:0] op, input logic [15:0] spd,
			input logic [7:0] dev, input logic rev, output wire_frame_t f);
		logic [7:0]  addr;
		logic [15:0] val;
		logic [15:0] crc;
		f = '0;
		case (op)
			OP_LEFT_SPEED: begin
				addr = ADDR_LO_SPEED;
				val  = clamp_speed(spd, rev);
			end
			OP_VEL_MODE: begin
				addr = ADDR_LO_MODE;
				val  = VAL_VEL_MODE;
			end
			OP_STOP: begin
				addr = ADDR_LO_CTRL;
				val  = VAL_STOP;
			end
			OP_ENABLE: begin
				addr = ADDR_LO_CTRL;
				val  = VAL_ENABLE;
			end
			OP_CLEAR_ALARM: begin
				addr = ADDR_LO_CTRL;
				val  = VAL_CLEAR_ALARM;
			end
			default: return 1'b0;
		endcase
		f[BYTE_DEV]     = dev;
		f[BYTE_FUNC]    = FUNC_WRITE_SINGLE;
		f[BYTE_ADDR_HI] = REG_PAGE;
		f[BYTE_ADDR_LO] = addr;
		f[BYTE_VAL_HI]  = val[15:8];
		f[BYTE_VAL_LO]  = val[7:0];
		crc             = modbus_crc(f);
		f[BYTE_CRC_LO]  = crc[7:0];
		f[BYTE_CRC_HI]  = crc[15:8];
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		wire_frame_t f;
		due_byte_t   d;
		int          k;
		if (!arst_n) begin
			dev_id_shadow  = DEVICE_ID_RESET;
			reverse_shadow = 1'b0;
			fail_count     = 0;
			checked_count  = 0;
			frame_count    = 0;
			bytes_expected.delete();
			mismatches    <= 0;
			bytes_due     <= 0;
			bytes_checked <= 0;
		end else begin
			// output transfer against the oldest expected byte
			if (frame_mon.valid && frame_mon.ready) begin
				checked_count++;
				if (bytes_expected.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected frame byte %02h last %0b",
							$realtime, frame_mon.frame_byte, frame_mon.last);
				end else begin
					d = bytes_expected.pop_front();
					if (frame_mon.frame_byte !== d.data || frame_mon.last !== d.last) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: frame %0d byte %0d: exp %02h/%0b, got %02h/%0b",
								$realtime, d.frame_no, d.pos, d.data, d.last,
								frame_mon.frame_byte, frame_mon.last);
					end
				end
			end

			// command transfer uses the settings in force before this edge
			if (cmd_mon.valid && cmd_mon.ready) begin
				if (build_frame(cmd_mon.opcode, cmd_mon.left_speed, dev_id_shadow,
						reverse_shadow, f)) begin
					for (k = 0; k < 8; k++) begin
						d.data     = f[k];
						d.last     = (k == int'(BYTE_CRC_HI));
						d.frame_no = frame_count;
						d.pos      = k;
						bytes_expected.insert(bytes_expected.size(), d);
					end
					frame_count++;
				end
			end

			// register writes
			if (cfg_we) begin
				if (cfg_index == CFG_DEVICE_ID)
					dev_id_shadow = cfg_data[7:0];
				else if (cfg_index == CFG_LEFT_REVERSE)
					reverse_shadow = cfg_data[0];
			end

			mismatches    <= fail_count;
			bytes_due     <= bytes_expected.size();
			bytes_checked <= checked_count;
		end
	end

endmodule

/* bench/testbench.sv */
// top of the frame builder bench: clock, reset, command and register stimulus, verdict
`timescale 1ns / 1ps

module testbench;
	import mwfb_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PRESSURE_HOLD  = 400;
	localparam int SETTLE_CYCLES  = 8;
	// codes outside the command set, ignored by the block
	localparam logic [2:0] OP_UNUSED_LO = 3'd5;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;
	// speeds around the limit, the wrap point and zero
	localparam logic [15:0] EXTREME_SPEEDS [9] = '{
		16'h7FFF, 16'h8000, 16'h0000, 16'h0BB7, 16'h0BB8,
		16'hF449, 16'hF448, 16'h0001, 16'hFFFF
	};

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	int                     mismatches;
	int                     bytes_due;
	int                     bytes_checked;
	int                     cmds_sent;
	int                     cmds_ignored;
	int                     settings_used;
	int                     idle_cycles;
	bit                     hold_req;
	bit                     hold_done;
	bit                     full_rate;

	mwfb_cmd_if  cmd_ch ();
	mwfb_byte_if frame_ch ();

	modbus_write_frame_builder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.frame     (frame_ch)
	);

	mwfb_frame_checker frame_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd_mon       (cmd_ch),
		.frame_mon     (frame_ch),
		.mismatches    (mismatches),
		.bytes_due     (bytes_due),
		.bytes_checked (bytes_checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// speed mix: small values, around the limit, extremes, anything
	function automatic logic [15:0] rand_speed();
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0: v = $urandom_range(0, 200) - 100;
			1: begin
				v = $urandom_range(2996, 3002);
				if ($urandom_range(0, 1))
					v = 0 - v;
			end
			2: v = 32'(EXTREME_SPEEDS[$urandom_range(0, 8)]);
			default: v = $urandom;
		endcase
		return v[15:0];
	endfunction

	// speed commands weighted up, a few unused codes
	function automatic logic [2:0] rand_op();
		int r;
		r = $urandom_range(0, 19);
		if (r < 7)
			return OP_LEFT_SPEED;
		if (r < 18)
			return 3'($urandom_range(int'(OP_VEL_MODE), int'(OP_CLEAR_ALARM)));
		return 3'($urandom_range(int'(OP_UNUSED_LO), int'(OP_UNUSED_HI)));
	endfunction

	// offer one command and hold it until the transfer
	task automatic send_cmd(input logic [2:0] op, input logic [15:0] spd);
		cmd_ch.valid      <= 1'b1;
		cmd_ch.opcode     <= op;
		cmd_ch.left_speed <= spd;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		cmds_sent++;
		if (op > OP_CLEAR_ALARM)
			cmds_ignored++;
	endtask

	// drop valid for a while with junk on the payload
	task automatic idle_gap(input int n);
		if (n > 0) begin
			cmd_ch.valid      <= 1'b0;
			cmd_ch.opcode     <= 3'($urandom);
			cmd_ch.left_speed <= 16'($urandom);
			repeat (n) @(posedge clk);
		end
	endtask

	// wait until every expected byte is out, then let the pipeline settle
	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (bytes_due != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] dev, input logic rev);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DEVICE_ID;
		cfg_data  <= dev;
		@(posedge clk);
		cfg_index <= CFG_LEFT_REVERSE;
		cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, rev};
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// random commands until n real frames were requested
	task automatic run_random(input int n, input bit pressure);
		int         done;
		logic [2:0] op;
		done = 0;
		while (done < n) begin
			op = rand_op();
			if (pressure && done == 5)
				hold_req = 1'b1;
			send_cmd(op, rand_speed());
			if (op <= OP_CLEAR_ALARM)
				done++;
			// keep offering back to back at full rate or while the output is held off
			if (!full_rate && !(hold_req && !hold_done))
				idle_gap(pick_gap());
		end
	endtask

	// command side and verdict
	initial begin
		int k;
		arst_n            <= 1'b0;
		cmd_ch.valid      <= 1'b0;
		cmd_ch.opcode     <= OP_LEFT_SPEED;
		cmd_ch.left_speed <= '0;
		cfg_we            <= 1'b0;
		cfg_index         <= CFG_DEVICE_ID;
		cfg_data          <= '0;
		cmds_sent     = 0;
		cmds_ignored  = 0;
		settings_used = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: speed corners, every command, the unused codes
		for (k = 0; k < 9; k++) begin
			send_cmd(OP_LEFT_SPEED, EXTREME_SPEEDS[k]);
			idle_gap(pick_gap());
		end
		for (k = int'(OP_VEL_MODE); k <= int'(OP_UNUSED_HI); k++) begin
			send_cmd(k[2:0], 16'($urandom));
			idle_gap(pick_gap());
		end

		// reversed direction, top device id: negation wrap and saturation
		wait_idle();
		set_config(8'hFF, 1'b1);
		for (k = 0; k < 9; k++) begin
			send_cmd(OP_LEFT_SPEED, EXTREME_SPEEDS[k]);
			idle_gap(pick_gap());
		end

		// random phases over several settings, one with a long output stall
		wait_idle();
		set_config(8'h00, 1'b0);
		run_random(75, 1'b1);
		wait_idle();
		full_rate = 1'b1;
		set_config(8'($urandom), 1'b1);
		run_random(75, 1'b0);
		wait_idle();
		full_rate = 1'b0;
		set_config(8'hFF, 1'b0);
		run_random(75, 1'b0);
		wait_idle();
		set_config(8'($urandom), 1'($urandom));
		run_random(70, 1'b0);
		wait_idle();
		set_config(DEVICE_ID_RESET, 1'b1);
		run_random(70, 1'b0);
		wait_idle();

		$display("summary: %0d commands (%0d with unused codes), %0d frame bytes compared",
			cmds_sent, cmds_ignored, bytes_checked);
		$display("summary: %0d register settings, device id 0 and 255, both directions, %0d-cycle hold",
			settings_used, PRESSURE_HOLD);
		if (mismatches == 0 && bytes_due == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// output side: random stalls, one long hold, full rate on request
	initial begin
		int stall;
		frame_ch.ready <= 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				frame_ch.ready <= 1'b0;
				repeat (PRESSURE_HOLD) @(posedge clk);
				hold_done = 1'b1;
			end else if (full_rate) begin
				frame_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				frame_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				stall = pick_gap();
				if (stall > 0) begin
					frame_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (frame_ch.valid && frame_ch.ready)
				|| cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d bytes outstanding",
				WATCHDOG_LIMIT, bytes_due);
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
